// ----- src/sjd_pkg.sv -----
`timescale 1ns / 1ps

package sjd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WcharW = 14;
  localparam int unsigned StatW  = 2;

  localparam logic [StatW-1:0] ST_SINGLE  = 2'd0;
  localparam logic [StatW-1:0] ST_DOUBLE  = 2'd1;
  localparam logic [StatW-1:0] ST_INVALID = 2'd2;
  localparam logic [StatW-1:0] ST_END     = 2'd3;

  localparam logic [ByteW-1:0] ASCII_MAX  = 8'h7f;
  localparam logic [ByteW-1:0] KANA_MIN   = 8'ha1;
  localparam logic [ByteW-1:0] KANA_MAX   = 8'hdf;
  localparam logic [ByteW-1:0] LEAD1_MIN  = 8'h81;
  localparam logic [ByteW-1:0] LEAD1_MAX  = 8'h9f;
  localparam logic [ByteW-1:0] LEAD2_MIN  = 8'he0;
  localparam logic [ByteW-1:0] LEAD2_MAX  = 8'hfc;
  localparam logic [ByteW-1:0] TRAIL_MIN  = 8'h40;
  localparam logic [ByteW-1:0] TRAIL_MAX  = 8'hfc;
  localparam logic [ByteW-1:0] TRAIL_HOLE = 8'h7f;

  localparam logic [WcharW-1:0] OFFSET1 = 14'h0100;
  localparam logic [WcharW-1:0] OFFSET2 = 14'h189f;

  // Decoder state carried between bytes.
  typedef struct packed {
    logic             pending;
    logic [ByteW-1:0] lead;
  } lead_state_t;

  typedef struct packed {
    logic [WcharW-1:0] wide_char;
    logic [StatW-1:0]  status;
    logic [ByteW-1:0]  pushback_byte;
    logic              pushback_is_end;
  } result_t;

endpackage

// ----- src/sjd_decode.sv -----
`timescale 1ns / 1ps

module sjd_decode (
  input  sjd_pkg::lead_state_t state,
  input  logic [7:0]           in_byte,
  input  logic                 end_of_input,
  output logic                 has_result,
  output sjd_pkg::result_t     result,
  output sjd_pkg::lead_state_t state_next
);
  import sjd_pkg::*;

  logic              is_trail;
  logic              is_single;
  logic              is_lead;
  logic [ByteW-1:0]  trail_off;
  logic [ByteW-1:0]  lead_off;
  logic [WcharW-1:0] two_byte;

  assign is_trail  = (in_byte >= TRAIL_MIN) && (in_byte <= TRAIL_MAX) &&
                     (in_byte != TRAIL_HOLE);
  assign is_single = (in_byte <= ASCII_MAX) ||
                     ((in_byte >= KANA_MIN) && (in_byte <= KANA_MAX));
  assign is_lead   = ((in_byte >= LEAD1_MIN) && (in_byte <= LEAD1_MAX)) ||
                     ((in_byte >= LEAD2_MIN) && (in_byte <= LEAD2_MAX));
  assign trail_off = in_byte - TRAIL_MIN;

  // Only the low five bits of the lead offset take part in the code.
  assign lead_off = (state.lead <= LEAD1_MAX) ? (state.lead - LEAD1_MIN)
                                              : (state.lead - LEAD2_MIN);
  assign two_byte = {1'b0, trail_off, lead_off[4:0]} +
                    ((state.lead <= LEAD1_MAX) ? OFFSET1 : OFFSET2);

  always_comb begin
    result     = '0;
    has_result = 1'b1;
    state_next = '0;
    if (state.pending) begin
      if (end_of_input) begin
        result.status          = ST_INVALID;
        result.pushback_is_end = 1'b1;
      end else if (is_trail) begin
        result.status    = ST_DOUBLE;
        result.wide_char = two_byte;
      end else begin
        result.status        = ST_INVALID;
        result.pushback_byte = in_byte;
      end
    end else if (end_of_input) begin
      result.status = ST_END;
    end else if (is_single) begin
      result.status    = ST_SINGLE;
      result.wide_char = {{(WcharW-ByteW){1'b0}}, in_byte};
    end else if (is_lead) begin
      has_result         = 1'b0;
      state_next.pending = 1'b1;
      state_next.lead    = in_byte;
    end else begin
      result.status        = ST_INVALID;
      result.pushback_byte = in_byte;
    end
  end

endmodule

// ----- src/shift_jis_dense_wide_char_decoder.sv -----
`timescale 1ns / 1ps

// Shift-JIS to dense wide character decoder. One byte or end marker is taken
// per transfer on the slave side, at a sustained rate of one per cycle while
// the master side accepts results; each item passes an input register, the
// range-compare and add logic, and the result register. A lead byte gives no
// result and is held for the following byte; any other item gives exactly one
// result. Back-pressure on the master side stalls the input register once it
// holds an item that has a result to deliver.
module shift_jis_dense_wide_char_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [13:0] wide_char, [21:14] pushback_byte, rest zero
  output logic [2:0]  m_tuser    // [1:0] status, [2] pushback_is_end
);
  import sjd_pkg::*;

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             in_end;
  lead_state_t      state;
  lead_state_t      state_next;
  logic             has_result;
  result_t          result;
  result_t          out_result;
  logic             out_free;
  logic             advance;

  sjd_decode u_decode (
    .state        (state),
    .in_byte      (in_byte),
    .end_of_input (in_end),
    .has_result   (has_result),
    .result       (result),
    .state_next   (state_next)
  );

  assign out_free = !m_tvalid || m_tready;
  // A held lead byte moves on even while the result register is full.
  assign advance  = in_valid && (!has_result || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_end  <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (out_free) begin
        m_tvalid <= advance && has_result;
      end
    end
    if (out_free && advance && has_result) begin
      out_result <= result;
    end
  end

  assign m_tdata = {2'b00, out_result.pushback_byte, out_result.wide_char};
  assign m_tuser = {out_result.pushback_is_end, out_result.status};

endmodule

// ----- test/sjd_checker.sv -----
`timescale 1ns / 1ps

module sjd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] end_of_input
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // [13:0] wide_char, [21:14] pushback_byte, rest zero
  input  logic [2:0]  m_tuser,   // [1:0] status, [2] pushback_is_end
  output int          mismatches,
  output int          outstanding
);
  import sjd_pkg::*;

  localparam int ReportMax = 10;

  // Shadow of the decoder's lead byte register.
  logic             lead_held = 1'b0;
  logic [ByteW-1:0] lead_val  = '0;

  result_t expected_chars[$];
  int      fail_total = 0;

  // Returns 1 when the item gives a result, which is then placed in res.
  function automatic logic decode_byte(input logic [ByteW-1:0] b, input logic eoi,
                                       output result_t res);
    logic [WcharW-1:0] idx;
    logic              trail_ok;
    res      = '0;
    trail_ok = (b >= TRAIL_MIN) && (b <= TRAIL_MAX) && (b != TRAIL_HOLE);
    if (lead_held) begin
      lead_held = 1'b0;
      if (eoi) begin
        res.status          = ST_INVALID;
        res.pushback_is_end = 1'b1;
      end else if (trail_ok) begin
        res.status = ST_DOUBLE;
        if (lead_val <= LEAD1_MAX) begin
          idx           = {1'b0, 8'(b - TRAIL_MIN), 5'(lead_val - LEAD1_MIN)};
          res.wide_char = idx + OFFSET1;
        end else begin
          idx           = {1'b0, 8'(b - TRAIL_MIN), 5'(lead_val - LEAD2_MIN)};
          res.wide_char = idx + OFFSET2;
        end
      end else begin
        res.status        = ST_INVALID;
        res.pushback_byte = b;
      end
      lead_val = '0;
      return 1'b1;
    end
    if (eoi) begin
      res.status = ST_END;
      return 1'b1;
    end
    if (b <= ASCII_MAX || (b >= KANA_MIN && b <= KANA_MAX)) begin
      res.status    = ST_SINGLE;
      res.wide_char = {6'b0, b};
      return 1'b1;
    end
    if ((b >= LEAD1_MIN && b <= LEAD1_MAX) || (b >= LEAD2_MIN && b <= LEAD2_MAX)) begin
      lead_held = 1'b1;
      lead_val  = b;
      return 1'b0;
    end
    res.status        = ST_INVALID;
    res.pushback_byte = b;
    return 1'b1;
  endfunction

  task automatic log_failure(input string what, input result_t want, input result_t got,
                             input logic [1:0] pad);
    fail_total++;
    if (fail_total <= ReportMax)
      $display("%0t: %s: expected wc=%h st=%0d pb=%h pe=%0b, got wc=%h st=%0d pb=%h pe=%0b pad=%b",
               $time, what, want.wide_char, want.status, want.pushback_byte,
               want.pushback_is_end, got.wide_char, got.status, got.pushback_byte,
               got.pushback_is_end, pad);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t fresh;
    if (rst) begin
      lead_held = 1'b0;
      lead_val  = '0;
      expected_chars.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.wide_char       = m_tdata[13:0];
        got.pushback_byte   = m_tdata[21:14];
        got.status          = m_tuser[1:0];
        got.pushback_is_end = m_tuser[2];
        if (expected_chars.size() == 0) begin
          log_failure("result with nothing expected", '0, got, m_tdata[23:22]);
        end else begin
          want = expected_chars.pop_front();
          if (got.wide_char != want.wide_char || got.status != want.status ||
              got.pushback_byte != want.pushback_byte ||
              got.pushback_is_end != want.pushback_is_end || m_tdata[23:22] != 2'b00)
            log_failure("result mismatch", want, got, m_tdata[23:22]);
        end
      end
      if (s_tvalid && s_tready) begin
        if (decode_byte(s_tdata, s_tuser, fresh))
          expected_chars.push_back(fresh);
      end
    end
    mismatches  <= fail_total;
    outstanding <= expected_chars.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit = 100000;
  localparam int PhaseItems = 145;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;

  int   mismatches;
  int   outstanding;
  int   cycles = 0;
  int   tx_idle_pct = 14;
  int   rx_stall_pct = 52;
  int   items_sent = 0;
  int   hold_left = 0;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;

  shift_jis_dense_wide_char_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  sjd_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off so that the decoder fills
  // up and has to refuse bytes.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= 80;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= eoi;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  function automatic logic [7:0] any_lead();
    return $urandom_range(1) ? 8'($urandom_range(8'h81, 8'h9f))
                             : 8'($urandom_range(8'he0, 8'hfc));
  endfunction

  task automatic send_random();
    logic [7:0] t;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_item(any_lead(), 1'b0);
      do t = 8'($urandom_range(8'h40, 8'hfc)); while (t == 8'h7f);
      send_item(t, 1'b0);
    end else if (pick < 65) begin
      t = $urandom_range(1) ? 8'($urandom_range(8'h00, 8'h7f))
                            : 8'($urandom_range(8'ha1, 8'hdf));
      send_item(t, 1'b0);
    end else if (pick < 75) begin
      // Lead byte followed by something that cannot be a trail byte.
      case ($urandom_range(2))
        0:       t = 8'($urandom_range(8'h00, 8'h3f));
        1:       t = 8'h7f;
        default: t = 8'($urandom_range(8'hfd, 8'hff));
      endcase
      send_item(any_lead(), 1'b0);
      send_item(t, 1'b0);
    end else if (pick < 80) begin
      send_item(any_lead(), 1'b0);
      send_item(8'($urandom), 1'b1);
    end else if (pick < 85) begin
      send_item(8'($urandom), 1'b1);
    end else begin
      send_item(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: range edges, invalid single bytes, end markers, both
    // lead ranges with edge trail bytes, and each way a trail byte can fail.
    send_item(8'h00, 1'b0);
    send_item(8'h7f, 1'b0);
    send_item(8'ha1, 1'b0);
    send_item(8'hdf, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'ha0, 1'b0);
    send_item(8'hfd, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b1);
    send_item(8'h81, 1'b0);
    send_item(8'h40, 1'b0);
    send_item(8'h9f, 1'b0);
    send_item(8'hfc, 1'b0);
    send_item(8'he0, 1'b0);
    send_item(8'h7e, 1'b0);
    send_item(8'hfc, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h81, 1'b0);
    send_item(8'h7f, 1'b0);
    send_item(8'he0, 1'b0);
    send_item(8'h3f, 1'b0);
    send_item(8'h9f, 1'b0);
    send_item(8'hfd, 1'b0);
    send_item(8'hfc, 1'b0);
    send_item(8'haa, 1'b1);

    while (items_sent < 25 + PhaseItems) send_random();

    tx_idle_pct = 52;
    rx_stall_pct <= 14;
    while (items_sent < 25 + 2 * PhaseItems) send_random();

    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    while (items_sent < 25 + 3 * PhaseItems) begin
      if (items_sent >= 25 + 2 * PhaseItems + 40) hold_request <= 1'b1;
      send_random();
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
